### hw/rtl/tvtc_pkg.sv
// ----------------------------------------------------------------------------
// tvtc_pkg
// Shared types and constants for the type K thermocouple linearizer.
// ----------------------------------------------------------------------------
package tvtc_pkg;

    // Table geometry. The search uses the first ACT_POINTS entries.
    localparam int ROM_POINTS   = 66;
    localparam int TABLE_POINTS = 65;
    localparam int ACT_POINTS   = (TABLE_POINTS < 2) ? 2 :
                                  (TABLE_POINTS > ROM_POINTS) ? ROM_POINTS : TABLE_POINTS;
    localparam int ADDR_W       = $clog2(ROM_POINTS);

    // Field widths.
    localparam int UV_W    = 16;               // measured microvolts
    localparam int AMB_W   = 18;               // ambient millidegrees
    localparam int TEMP_W  = 21;               // temperature in millidegrees
    localparam int X_W     = 18;               // search value (ambient or voltage sum)
    localparam int DIFF_W  = 16;               // largest step between two table values
    localparam int PROD_W  = DIFF_W + X_W;     // interpolation numerator
    localparam int CNT_W   = $clog2(PROD_W + 1);
    localparam int ENTRY_W = TEMP_W + UV_W;    // table word: {temperature, microvolts}

    localparam logic [TEMP_W-1:0] OUT_MAX = {TEMP_W{1'b1}};

    // Table of (temperature, microvolts) points.
    localparam logic [TEMP_W-1:0] ROM_TEMP [ROM_POINTS] = '{
        21'd0, 21'd10000, 21'd20000, 21'd30000, 21'd40000, 21'd50000, 21'd60000,
        21'd79000, 21'd98000, 21'd116000, 21'd134000, 21'd139000, 21'd155000,
        21'd172000, 21'd193000, 21'd212000, 21'd231000, 21'd250000, 21'd269000,
        21'd288000, 21'd307000, 21'd326000, 21'd345000, 21'd364000, 21'd383000,
        21'd402000, 21'd421000, 21'd440000, 21'd459000, 21'd478000, 21'd497000,
        21'd516000, 21'd535000, 21'd554000, 21'd573000, 21'd592000, 21'd611000,
        21'd630000, 21'd649000, 21'd668000, 21'd687000, 21'd706000, 21'd725000,
        21'd744000, 21'd763000, 21'd782000, 21'd801000, 21'd820000, 21'd839000,
        21'd858000, 21'd877000, 21'd896000, 21'd915000, 21'd934000, 21'd953000,
        21'd972000, 21'd991000, 21'd1010000, 21'd1029000, 21'd1048000,
        21'd1067000, 21'd1086000, 21'd1105000, 21'd1124000, 21'd1143000,
        21'd1200000
    };

    localparam logic [UV_W-1:0] ROM_UV [ROM_POINTS] = '{
        16'd0, 16'd397, 16'd798, 16'd1203, 16'd1612, 16'd2023, 16'd2436, 16'd3225,
        16'd4013, 16'd4756, 16'd5491, 16'd5694, 16'd6339, 16'd7021, 16'd7859,
        16'd8619, 16'd9383, 16'd10153, 16'd10930, 16'd11712, 16'd12499, 16'd13290,
        16'd14084, 16'd14881, 16'd15680, 16'd16482, 16'd17285, 16'd18091,
        16'd18898, 16'd19707, 16'd20516, 16'd21326, 16'd22137, 16'd22947,
        16'd23757, 16'd24565, 16'd25373, 16'd26179, 16'd26983, 16'd27784,
        16'd28584, 16'd29380, 16'd30174, 16'd30964, 16'd31752, 16'd32536,
        16'd33316, 16'd34093, 16'd34867, 16'd35637, 16'd36403, 16'd37166,
        16'd37925, 16'd38680, 16'd39432, 16'd40180, 16'd40924, 16'd41665,
        16'd42402, 16'd43134, 16'd43863, 16'd44588, 16'd45308, 16'd46024,
        16'd46735, 16'd48838
    };

    // Controller states.
    typedef enum logic [2:0] {
        S_FILL,
        S_IDLE,
        S_SCAN0,
        S_SCAN,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

endpackage

### hw/rtl/tvtc_ram.sv
// ----------------------------------------------------------------------------
// tvtc_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module tvtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/tvtc_div.sv
// ----------------------------------------------------------------------------
// tvtc_div
// Restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module tvtc_div
    import tvtc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_dividend,
    input  logic [TEMP_W-1:0] i_divisor,
    output logic              o_done,
    output logic [PROD_W-1:0] o_quotient
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt,  n_cnt;
    logic [TEMP_W-1:0] r_rem,  n_rem;
    logic [TEMP_W-1:0] r_dvs,  n_dvs;
    logic [PROD_W-1:0] r_dq,   n_dq;

    logic [TEMP_W:0]   rem_sh;
    logic              ge;

    // One shift-and-subtract step. The dividend shifts out of the top of
    // r_dq while quotient bits shift in at the bottom.
    always_comb begin
        rem_sh = {r_rem, r_dq[PROD_W-1]};
        ge     = (rem_sh >= {1'b0, r_dvs});
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_dq   = r_dq;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_dvs  = i_divisor;
            n_dq   = i_dividend;
        end else if (r_busy) begin
            n_rem = ge ? TEMP_W'(rem_sh - {1'b0, r_dvs}) : TEMP_W'(rem_sh);
            n_dq  = {r_dq[PROD_W-2:0], ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(PROD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_dq  <= n_dq;
    end

    assign o_done     = r_done;
    assign o_quotient = r_dq;

endmodule

### hw/rtl/thermocouple_voltage_to_temperature_core.sv
// ----------------------------------------------------------------------------
// thermocouple_voltage_to_temperature_core
// Type K thermocouple linearizer: microvolts to millidegrees Celsius by
// piecewise-linear interpolation over the first 65 of the 66 table points.
// ----------------------------------------------------------------------------
// Usage
// The slave stream carries one sample per transfer: measured microvolts in
// tdata[15:0] and the ambient temperature in tdata[33:16]. The master stream
// returns the hot-junction temperature in tdata[20:0], one transfer per
// sample. The cold-junction enable is written through i_cfg_we/i_cfg_wdata
// and resets to 1.
// After reset the table RAM is loaded from the package constants, one entry
// a cycle; s_axis_tready stays low until then.
// One sample is processed at a time. Each lookup reads entry 0 and then scans
// the table RAM one entry a cycle up to the first point above the value, or
// up to the last active point (index 64), then multiplies and runs the
// bit-serial divider. Compensation on takes two lookups, off takes one.
// The result sits in an output register; the core takes the next sample
// while it waits, and holds a second result back until the receiver has
// taken the first.
// ----------------------------------------------------------------------------
module thermocouple_voltage_to_temperature_core
    import tvtc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: cold_junction_enable.
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // [15:0] measured_microvolts, [33:16] ambient_millidegrees
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // [20:0] temperature_millidegrees
);

    t_state            r_state, n_state;
    logic              r_cje;
    logic [ADDR_W-1:0] r_addr,  n_addr;
    logic              r_phase, n_phase;     // 0: ambient to microvolts, 1: microvolts to temperature
    logic [UV_W-1:0]   r_uv,    n_uv;
    logic [X_W-1:0]    r_x,     n_x;
    logic [ENTRY_W-1:0] r_prev, n_prev;
    logic [DIFF_W-1:0] r_dy,    n_dy;
    logic [X_W-1:0]    r_dxx,   n_dxx;
    logic [TEMP_W-1:0] r_dx,    n_dx;
    logic [TEMP_W-1:0] r_y0,    n_y0;
    logic [PROD_W-1:0] r_prod,  n_prod;
    logic              r_div_go;
    logic              r_out_valid, n_out_valid;
    logic [TEMP_W-1:0] r_out_data,  n_out_data;

    logic               in_xfer;
    logic               out_free;
    logic [ENTRY_W-1:0] rd_data;
    logic [ENTRY_W-1:0] wr_data;
    logic [TEMP_W-1:0]  cur_key, cur_val, prev_key, prev_val;
    logic               hit;
    logic               div_done;
    logic [PROD_W-1:0]  div_q;
    logic [PROD_W:0]    lerp;
    logic [PROD_W+1:0]  uv_sum;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    // Table RAM, loaded from the package constants after reset.
    assign wr_data = {ROM_TEMP[r_addr], ROM_UV[r_addr]};

    tvtc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ROM_POINTS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_FILL),
        .i_wr_addr (r_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (n_addr),
        .o_rd_data (rd_data)
    );

    // Key and value of the entry at r_addr and of the one before it. The
    // search runs on temperature in the ambient lookup and on voltage in the
    // voltage lookup.
    always_comb begin
        if (r_phase) begin
            cur_key  = TEMP_W'(rd_data[UV_W-1:0]);
            cur_val  = rd_data[ENTRY_W-1:UV_W];
            prev_key = TEMP_W'(r_prev[UV_W-1:0]);
            prev_val = r_prev[ENTRY_W-1:UV_W];
        end else begin
            cur_key  = rd_data[ENTRY_W-1:UV_W];
            cur_val  = TEMP_W'(rd_data[UV_W-1:0]);
            prev_key = r_prev[ENTRY_W-1:UV_W];
            prev_val = TEMP_W'(r_prev[UV_W-1:0]);
        end
    end

    // The segment ends at the first point above the value, or at the last
    // active point when the value lies beyond the table.
    assign hit = (cur_key > TEMP_W'(r_x)) || (r_addr == ADDR_W'(ACT_POINTS - 1));

    // Numerator over segment width, truncated.
    tvtc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_prod),
        .i_divisor  (r_dx),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // A zero-width segment yields its start value.
    assign lerp   = (r_dx == '0) ? (PROD_W + 1)'(r_y0) :
                    ((PROD_W + 1)'(r_y0) + (PROD_W + 1)'(div_q));
    assign uv_sum = (PROD_W + 2)'(r_uv) + (PROD_W + 2)'(lerp);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_FILL:  if (r_addr == ADDR_W'(ROM_POINTS - 1)) n_state = S_IDLE;
            S_IDLE:  if (in_xfer) n_state = S_SCAN0;
            S_SCAN0: n_state = S_SCAN;
            S_SCAN:  if (hit) n_state = S_MUL;
            S_MUL:   n_state = S_DIV;
            S_DIV:   if (div_done) n_state = r_phase ? S_DONE : S_SCAN0;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and handshake outputs.
    always_comb begin
        n_addr      = r_addr;
        n_phase     = r_phase;
        n_uv        = r_uv;
        n_x         = r_x;
        n_prev      = r_prev;
        n_dy        = r_dy;
        n_dxx       = r_dxx;
        n_dx        = r_dx;
        n_y0        = r_y0;
        n_prod      = r_prod;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        s_axis_tready = 1'b0;
        unique case (r_state)
            S_FILL: begin
                n_addr = (r_addr == ADDR_W'(ROM_POINTS - 1)) ? '0 : r_addr + 1'b1;
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
                n_addr        = '0;
                n_uv          = s_axis_tdata[UV_W-1:0];
                if (r_cje) begin
                    n_phase = 1'b0;
                    n_x     = s_axis_tdata[UV_W+AMB_W-1:UV_W];
                end else begin
                    n_phase = 1'b1;
                    n_x     = X_W'(s_axis_tdata[UV_W-1:0]);
                end
            end
            S_SCAN0: begin
                // Entry 0 is the start of the first candidate segment.
                n_prev = rd_data;
                n_addr = ADDR_W'(1);
            end
            S_SCAN: begin
                if (hit) begin
                    n_dy  = DIFF_W'(cur_val - prev_val);
                    n_dxx = X_W'(TEMP_W'(r_x) - prev_key);
                    n_dx  = cur_key - prev_key;
                    n_y0  = prev_val;
                end else begin
                    n_prev = rd_data;
                    n_addr = r_addr + 1'b1;
                end
            end
            S_MUL: begin
                n_prod = PROD_W'(r_dy) * PROD_W'(r_dxx);
            end
            S_DIV: begin
                n_addr = '0;
                if (div_done && !r_phase) begin
                    n_x     = X_W'(uv_sum);
                    n_phase = 1'b1;
                end
            end
            S_DONE: begin
                // The quotient and segment start stay put here, so the result
                // is loaded only once the output register is free.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = (lerp > (PROD_W + 1)'(OUT_MAX)) ? OUT_MAX : TEMP_W'(lerp);
                end
            end
            default: begin
                n_addr = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_addr      <= '0;
            r_cje       <= 1'b1;
            r_div_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_div_go    <= (r_state == S_MUL);
            r_out_valid <= n_out_valid;
            if (i_cfg_we) r_cje <= i_cfg_wdata;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_phase    <= n_phase;
        r_uv       <= n_uv;
        r_x        <= n_x;
        r_prev     <= n_prev;
        r_dy       <= n_dy;
        r_dxx      <= n_dxx;
        r_dx       <= n_dx;
        r_y0       <= n_y0;
        r_prod     <= n_prod;
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = 24'(r_out_data);

    // The divider finishes only while the controller waits for it.
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider finished outside the divide state");

    // The scan never reads beyond the active points.
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_addr < ADDR_W'(ACT_POINTS))
        else $error("table scan beyond the active points");

    // An accepted sample always starts a scan at entry 0.
    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_SCAN0) && (r_addr == '0))
        else $error("accepted sample did not start a scan");

    // A new result is only loaded from the final state.
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state) == S_DONE)
        else $error("result presented outside the final state");

endmodule

### tb/tb_thermocouple_voltage_to_temperature_core.sv
// ----------------------------------------------------------------------------
// tb_thermocouple_voltage_to_temperature_core
// Self-checking bench for the type K thermocouple linearizer. Samples are
// streamed in, in some tests with random gaps and random output stalls. Each
// accepted sample is converted by a local piecewise-linear model under the
// current cold-junction compensation mode, and every returned temperature is
// compared in order against those predictions.
// ----------------------------------------------------------------------------
module tb_thermocouple_voltage_to_temperature_core
    import tvtc_pkg::*;
();

    localparam int NUM_POINTS    = 66;
    localparam int ACTIVE_POINTS = ACT_POINTS;
    localparam longint unsigned TEMP_LIMIT = 64'd2097151;
    localparam int CYCLE_LIMIT   = 1500000;
    localparam int TAIL_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;

    // Type K calibration points: temperature in millidegrees, voltage in microvolts.
    localparam int unsigned KTC_TEMP [NUM_POINTS] = '{
        0, 10000, 20000, 30000, 40000, 50000, 60000, 79000, 98000, 116000,
        134000, 139000, 155000, 172000, 193000, 212000, 231000, 250000, 269000,
        288000, 307000, 326000, 345000, 364000, 383000, 402000, 421000, 440000,
        459000, 478000, 497000, 516000, 535000, 554000, 573000, 592000, 611000,
        630000, 649000, 668000, 687000, 706000, 725000, 744000, 763000, 782000,
        801000, 820000, 839000, 858000, 877000, 896000, 915000, 934000, 953000,
        972000, 991000, 1010000, 1029000, 1048000, 1067000, 1086000, 1105000,
        1124000, 1143000, 1200000
    };

    localparam int unsigned KTC_UV [NUM_POINTS] = '{
        0, 397, 798, 1203, 1612, 2023, 2436, 3225, 4013, 4756,
        5491, 5694, 6339, 7021, 7859, 8619, 9383, 10153, 10930,
        11712, 12499, 13290, 14084, 14881, 15680, 16482, 17285, 18091,
        18898, 19707, 20516, 21326, 22137, 22947, 23757, 24565, 25373,
        26179, 26983, 27784, 28584, 29380, 30174, 30964, 31752, 32536,
        33316, 34093, 34867, 35637, 36403, 37166, 37925, 38680, 39432,
        40180, 40924, 41665, 42402, 43134, 43863, 44588, 45308,
        46024, 46735, 48838
    };

    // Highest point index whose temperature fits in the ambient field.
    localparam int LAST_AMB_POINT = 17;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;  // [15:0] measured_microvolts, [33:16] ambient_millidegrees
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;       // [20:0] temperature_millidegrees

    // Predicted temperatures, oldest first.
    logic [TEMP_W-1:0] temp_expected [$];

    logic cold_junction_on = 1'b1;
    bit   sender_gaps      = 1'b0;
    bit   receiver_stalls  = 1'b0;
    int   stall_left       = 0;
    int   cycle_count      = 0;
    int   samples_sent     = 0;
    int   temps_checked    = 0;
    int   mismatch_count   = 0;

    thermocouple_voltage_to_temperature_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock with a period of 8.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Run watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d temperatures outstanding.",
                     cycle_count, temp_expected.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Returns the index of the first active point whose key is above x, or the
    // last active point when there is none.
    function automatic int segment_end(input bit on_temp_axis, input longint unsigned x);
        int k;
        longint unsigned key;
        for (k = 0; k < ACTIVE_POINTS; k++) begin
            key = on_temp_axis ? 64'(KTC_TEMP[k]) : 64'(KTC_UV[k]);
            if (key > x) break;
        end
        if (k >= ACTIVE_POINTS) k = ACTIVE_POINTS - 1;
        if (k == 0) k = 1;
        return k;
    endfunction

    // Interpolates (or extrapolates) along the segment ending at point k.
    function automatic longint unsigned interpolate(input bit temp_to_uv, input int k,
                                                    input longint unsigned x);
        longint unsigned x0, x1, y0, y1;
        x0 = temp_to_uv ? 64'(KTC_TEMP[k-1]) : 64'(KTC_UV[k-1]);
        x1 = temp_to_uv ? 64'(KTC_TEMP[k])   : 64'(KTC_UV[k]);
        y0 = temp_to_uv ? 64'(KTC_UV[k-1])   : 64'(KTC_TEMP[k-1]);
        y1 = temp_to_uv ? 64'(KTC_UV[k])     : 64'(KTC_TEMP[k]);
        if (x1 == x0) return y0;
        return y0 + (y1 - y0) * (x - x0) / (x1 - x0);
    endfunction

    // Hot-junction temperature for one sample under the current compensation mode.
    function automatic logic [TEMP_W-1:0] hot_junction_temp(input logic [UV_W-1:0] uv,
                                                            input logic [AMB_W-1:0] amb,
                                                            input logic comp_on);
        longint unsigned total_uv, temp, amb_x;
        amb_x    = 64'(amb);
        total_uv = 64'(uv);
        if (comp_on)
            total_uv += interpolate(1'b1, segment_end(1'b1, amb_x), amb_x);
        temp = interpolate(1'b0, segment_end(1'b0, total_uv), total_uv);
        if (temp > TEMP_LIMIT) temp = TEMP_LIMIT;
        return temp[TEMP_W-1:0];
    endfunction

    // Random voltage, biased towards calibration points and the field limits.
    function automatic logic [UV_W-1:0] pick_uv();
        int sel;
        int p;
        sel = $urandom_range(0, 19);
        p   = $urandom_range(0, NUM_POINTS - 1);
        if (sel < 2)
            return UV_W'(KTC_UV[p] + $urandom_range(0, 2) - 1 + (p == 0 ? 1 : 0));
        else if (sel == 2)
            return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd0;
        else if (sel == 3)
            return UV_W'($urandom_range(46000, 65535));
        return UV_W'($urandom_range(0, 65535));
    endfunction

    // Random ambient, mostly within the rated range with a few up to the field limit.
    function automatic logic [AMB_W-1:0] pick_amb();
        int sel;
        int p;
        sel = $urandom_range(0, 19);
        p   = $urandom_range(0, LAST_AMB_POINT);
        if (sel < 3)
            return AMB_W'(KTC_TEMP[p] + $urandom_range(0, 2) - 1 + (p == 0 ? 1 : 0));
        else if (sel == 3)
            return AMB_W'($urandom_range(200001, 262143));
        else if (sel == 4)
            return ($urandom_range(0, 1) != 0) ? 18'd200000 : 18'd0;
        return AMB_W'($urandom_range(0, 200000));
    endfunction

    // Sends one sample and records its predicted temperature once transferred.
    // Called and left at a falling edge; tvalid stays high for a following sample.
    task automatic send_sample(input logic [UV_W-1:0] uv, input logic [AMB_W-1:0] amb);
        int gap;
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, amb, uv};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        temp_expected.push_back(hot_junction_temp(uv, amb, cold_junction_on));
        samples_sent++;
        @(negedge i_clk);
    endtask

    // Holds the input off until every predicted temperature has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (temp_expected.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Writes the cold-junction enable while the core is idle.
    task automatic write_cold_junction(input logic enable);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= enable;
        cold_junction_on = enable;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_sample(pick_uv(), pick_amb());
    endtask

    // Compensation on from reset: zero, exact points, field limits, extrapolation.
    task automatic test_compensated_corners();
        send_sample(16'd0, 18'd0);
        send_sample(16'd0, 18'd10000);
        send_sample(16'd0, 18'd9999);
        send_sample(16'd0, 18'd60000);
        send_sample(16'd0, 18'd200000);
        send_sample(16'd0, 18'h3FFFF);
        send_sample(16'hFFFF, 18'd200000);
        send_sample(16'hFFFF, 18'h3FFFF);
        send_sample(16'd46735, 18'd0);
        send_sample(16'd44299, 18'd60000);
        send_sample(16'h5555, 18'h2AAAA);
        send_sample(16'hAAAA, 18'h15555);
    endtask

    // Compensation off: the ambient is ignored and the voltage maps directly.
    task automatic test_direct_corners();
        write_cold_junction(1'b0);
        send_sample(16'd0, 18'h3FFFF);
        send_sample(16'hFFFF, 18'd0);
        send_sample(16'd397, 18'd123456);
        send_sample(16'd396, 18'd0);
        send_sample(16'd398, 18'd0);
        send_sample(16'd2436, 18'd0);
        send_sample(16'd46735, 18'd0);
        send_sample(16'd46736, 18'd200000);
        send_sample(16'd48838, 18'd0);
        send_sample(16'd1, 18'd1);
    endtask

    // Random samples with compensation on, under gaps and stalls.
    task automatic test_random_compensated();
        write_cold_junction(1'b1);
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        send_random(450);
    endtask

    // Random samples with compensation off, stalls only on the output side.
    task automatic test_random_direct();
        write_cold_junction(1'b0);
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b1;
        send_random(350);
    endtask

    // Alternating modes, including repeated writes of the same value.
    task automatic test_mode_switching();
        int phase;
        sender_gaps = 1'b1;
        for (phase = 0; phase < 10; phase++) begin
            write_cold_junction(phase == 4 ? 1'b1 : phase[0]);
            receiver_stalls = phase[1];
            send_random(20);
        end
    endtask

    // The sender stops until the pipeline has fully drained, then resumes.
    task automatic test_drain_and_resume();
        receiver_stalls = 1'b1;
        send_random(20);
        wait_drained();
        send_random(20);
    endtask

    // Back-to-back samples with both sides always ready.
    task automatic test_full_rate();
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        write_cold_junction(1'b1);
        send_random(150);
        write_cold_junction(1'b0);
        send_random(100);
    endtask

    // Output-side ready with random stall bursts.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (receiver_stalls && $urandom_range(0, 11) == 0) begin
            stall_left    <= $urandom_range(1, 18) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compares every returned temperature with the oldest prediction.
    always @(posedge i_clk) begin
        logic [TEMP_W-1:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (temp_expected.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("Unexpected temperature %0d with nothing outstanding.",
                             m_axis_tdata[TEMP_W-1:0]);
            end else begin
                want = temp_expected.pop_front();
                temps_checked++;
                if (m_axis_tdata[TEMP_W-1:0] !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("Temperature mismatch on result %0d: expected %0d, got %0d.",
                                 temps_checked, want, m_axis_tdata[TEMP_W-1:0]);
                end
            end
        end
    end

    // Test sequence.
    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_compensated_corners();
        test_direct_corners();
        test_random_compensated();
        test_random_direct();
        test_mode_switching();
        test_drain_and_resume();
        test_full_rate();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (temp_expected.size() != 0) mismatch_count++;
        $display("Sent %0d samples and checked %0d temperatures, compensation on and off,",
                 samples_sent, temps_checked);
        $display("with input gaps, output stalls, a full drain and a back-to-back tail.");
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d failures.", mismatch_count);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### thermocouple_voltage_to_temperature_core.f
hw/rtl/tvtc_pkg.sv
hw/rtl/tvtc_ram.sv
hw/rtl/tvtc_div.sv
hw/rtl/thermocouple_voltage_to_temperature_core.sv
tb/tb_thermocouple_voltage_to_temperature_core.sv
